// ----- design/blhq_pkg.sv -----
// ----------------------------------------------------------------------------
// blhq_pkg
// Shared types and constants for the bounded list / history queue.
// ----------------------------------------------------------------------------
package blhq_pkg;

   localparam int DEPTH     = 16;
   localparam int ITEM_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CAP_MIN   = 2;

   localparam int OP_BITS   = 2;
   localparam int POS_BITS  = 4;
   localparam int DATA_BITS = 32;
   localparam int CSR_BITS  = 1;
   localparam int CSRD_BITS = 5;

   // configuration register indexes
   localparam logic [CSR_BITS-1:0] CSR_QUEUE_MODE = 1'd0;
   localparam logic [CSR_BITS-1:0] CSR_CAPACITY   = 1'd1;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;   // latch the request
      logic fetch;     // read the last held entry into the temp register
      logic exec;      // apply the operation and load the response
   } dp_cmd_type;

   typedef struct packed {
      logic needs_fetch;  // list-mode remove pending
   } dp_stat_type;

endpackage

// ----- design/blhq_ctrl.sv -----
// ----------------------------------------------------------------------------
// blhq_ctrl
// Sequencer: accept, optional fetch of the last entry, execute, respond.
// ----------------------------------------------------------------------------
module blhq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  blhq_pkg::dp_stat_type stat,
   output blhq_pkg::dp_cmd_type  cmd
);

   blhq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blhq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         blhq_pkg::ST_IDLE: begin
            if (req_valid) state_in = blhq_pkg::ST_FETCH;
         end
         blhq_pkg::ST_FETCH: begin
            state_in = blhq_pkg::ST_EXEC;
         end
         blhq_pkg::ST_EXEC: begin
            state_in = blhq_pkg::ST_RESP;
         end
         blhq_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = blhq_pkg::ST_IDLE;
         end
         default: state_in = blhq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.fetch   = 1'b0;
      cmd.exec    = 1'b0;
      case (state_ff)
         blhq_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         blhq_pkg::ST_FETCH: begin
            cmd.fetch = stat.needs_fetch;
         end
         blhq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         blhq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- design/blhq_datapath.sv -----
// ----------------------------------------------------------------------------
// blhq_datapath
// Entry cells, held count, configuration registers and response registers.
// ----------------------------------------------------------------------------
module blhq_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  blhq_pkg::dp_cmd_type               cmd,
   output blhq_pkg::dp_stat_type              stat,
   input  logic [blhq_pkg::OP_BITS-1:0]       req_operation,
   input  logic [blhq_pkg::POS_BITS-1:0]      req_position,
   input  logic [blhq_pkg::DATA_BITS-1:0]     req_new_item,
   input  logic                               csr_write_enable,
   input  logic [blhq_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [blhq_pkg::CSRD_BITS-1:0]     csr_write_data,
   output logic                               rsp_ok,
   output logic [blhq_pkg::DATA_BITS-1:0]     rsp_read_item,
   output logic [blhq_pkg::CNT_BITS-1:0]      rsp_item_count,
   output logic                               rsp_is_full,
   output logic                               rsp_is_empty
);

   localparam int NC = blhq_pkg::CNT_BITS;
   localparam int NI = blhq_pkg::IDX_BITS;
   localparam int NB = blhq_pkg::ITEM_BITS;

   // configuration
   logic                                  queue_mode_ff;
   logic [blhq_pkg::CSRD_BITS-1:0]        capacity_ff;

   // captured request
   blhq_pkg::op_type                      op_ff;
   logic [NI-1:0]                         pos_ff;
   logic [NB-1:0]                         item_ff;

   logic [NB-1:0]                         cells_ff [blhq_pkg::DEPTH];
   logic [NB-1:0]                         cells_in [blhq_pkg::DEPTH];
   logic [NC-1:0]                         count_ff, count_in;
   logic [NB-1:0]                         temp_ff;

   logic                                  ok_ff, ok_in;
   logic [blhq_pkg::DATA_BITS-1:0]        rd_ff, rd_in;
   logic [NC-1:0]                         cnt_out_ff;
   logic                                  full_ff, empty_ff;

   logic [NC-1:0]                         cap;
   logic [NC-1:0]                         pos_ext;
   logic [NC-1:0]                         n_adj;
   logic                                  held_full;
   logic                                  pos_valid;
   logic [NI-1:0]                         last_idx;
   logic [NI-1:0]                         rd_addr;
   logic [NB-1:0]                         rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_mode_ff <= 1'b0;
         capacity_ff   <= blhq_pkg::CSRD_BITS'(blhq_pkg::DEPTH);
      end else if (csr_write_enable) begin
         case (csr_index)
            blhq_pkg::CSR_QUEUE_MODE: queue_mode_ff <= csr_write_data[0];
            blhq_pkg::CSR_CAPACITY:   capacity_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= blhq_pkg::op_type'(req_operation);
         pos_ff  <= NI'(req_position);
         item_ff <= NB'(req_new_item);
      end
   end

   assign stat.needs_fetch = (op_ff == blhq_pkg::OP_REMOVE) && !queue_mode_ff;

   // capacity clamped to the legal range
   always_comb begin
      if (NC'(capacity_ff) < NC'(blhq_pkg::CAP_MIN)) begin
         cap = NC'(blhq_pkg::CAP_MIN);
      end else if (NC'(capacity_ff) > NC'(blhq_pkg::DEPTH)) begin
         cap = NC'(blhq_pkg::DEPTH);
      end else begin
         cap = NC'(capacity_ff);
      end
   end

   assign pos_ext   = NC'(pos_ff);
   assign held_full = (count_ff >= cap);
   assign pos_valid = (pos_ext < count_ff);
   assign n_adj     = held_full ? (count_ff - NC'(1)) : count_ff;
   assign last_idx  = NI'(count_ff - NC'(1));

   // single read port: last entry during fetch, requested position otherwise
   assign rd_addr = cmd.fetch ? last_idx : pos_ff;
   assign rd_data = cells_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (cmd.fetch) temp_ff <= rd_data;
   end

   always_comb begin
      for (int i = 0; i < blhq_pkg::DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      count_in = count_ff;
      ok_in    = 1'b0;
      rd_in    = '0;
      case (op_ff)
         blhq_pkg::OP_ADD: begin
            if (queue_mode_ff) begin
               ok_in       = 1'b1;
               cells_in[0] = item_ff;
               for (int i = 1; i < blhq_pkg::DEPTH; i++) begin
                  if (NC'(i) <= n_adj) cells_in[i] = cells_ff[i-1];
               end
               count_in = n_adj + NC'(1);
            end else if (!held_full) begin
               ok_in                 = 1'b1;
               cells_in[NI'(count_ff)] = item_ff;
               count_in              = count_ff + NC'(1);
            end
         end
         blhq_pkg::OP_REMOVE: begin
            if (pos_valid) begin
               ok_in = 1'b1;
               if (queue_mode_ff) begin
                  // close the gap toward the head
                  for (int i = 0; i < blhq_pkg::DEPTH - 1; i++) begin
                     if ((NC'(i) >= pos_ext) && (NC'(i + 1) < count_ff)) begin
                        cells_in[i] = cells_ff[i+1];
                     end
                  end
               end else begin
                  cells_in[pos_ff] = temp_ff;
               end
               count_in = count_ff - NC'(1);
            end
         end
         blhq_pkg::OP_GET: begin
            if (pos_valid) begin
               ok_in = 1'b1;
               rd_in = blhq_pkg::DATA_BITS'(rd_data);
            end
         end
         blhq_pkg::OP_CLEAR: begin
            ok_in    = 1'b1;
            count_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < blhq_pkg::DEPTH; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff      <= ok_in;
         rd_ff      <= rd_in;
         cnt_out_ff <= count_in;
         full_ff    <= (count_in >= cap);
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_ok         = ok_ff;
   assign rsp_read_item  = rd_ff;
   assign rsp_item_count = cnt_out_ff;
   assign rsp_is_full    = full_ff;
   assign rsp_is_empty   = empty_ff;

endmodule

// ----- design/bounded_list_or_history_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_list_or_history_queue
// Bounded item store, plain list or newest-first queue, one response per op.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  req       req_valid/req_stall, operation,pos,item  in
//  rsp       rsp_valid/rsp_stall, ok,data,count,flags out
//  csr       csr_write_enable, csr_index, data        in
//
//  An item passes through capture (accept), fetch (reads the last entry for a
//  list remove), execute and respond in order; rsp_valid rises in the respond
//  step. The response holds while rsp_stall is high.
//  The entry cells update in parallel in the execute cycle.
//  Reset clears the held count and queue mode and sets the capacity to DEPTH;
//  entry data is not cleared. req_stall stays high from accept until the response transfer completes.
// ----------------------------------------------------------------------------
module bounded_list_or_history_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [blhq_pkg::OP_BITS-1:0]       req_operation,
   input  logic [blhq_pkg::POS_BITS-1:0]      req_position,
   input  logic [blhq_pkg::DATA_BITS-1:0]     req_new_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_ok,
   output logic [blhq_pkg::DATA_BITS-1:0]     rsp_read_item,
   output logic [blhq_pkg::CNT_BITS-1:0]      rsp_item_count,
   output logic                               rsp_is_full,
   output logic                               rsp_is_empty,
   input  logic                               csr_write_enable,
   input  logic [blhq_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [blhq_pkg::CSRD_BITS-1:0]     csr_write_data
);

   blhq_pkg::dp_cmd_type  cmd;
   blhq_pkg::dp_stat_type stat;

   blhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   blhq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_new_item     (req_new_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ok           (rsp_ok),
      .rsp_read_item    (rsp_read_item),
      .rsp_item_count   (rsp_item_count),
      .rsp_is_full      (rsp_is_full),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule
